>>> rtl/core/hxdm_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the X-drive wheel mixer.
// Depends on nothing; every other file of the mixer but hxdm_checker refers to it by scoped names.
`default_nettype none

package hxdm_pkg;

    localparam int ITERS = 16;
    localparam int IDX_W = 4;
    localparam int SPEED_W = 15;
    localparam int CFG_IDX_W = 2;
    localparam int VEC_W = 34;
    localparam int ROT_W = 34;
    localparam int POW_W = 17;
    localparam int WHEEL_W = 17;
    localparam int MAG_W = 29;

    localparam logic [30:0] GAIN_INV = 31'd652032874;
    localparam logic [14:0] ARC_FULL = 15'd32512;
    localparam logic [SPEED_W-1:0] MIN_SPEED_RESET = 15'd0;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 15'd32512;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd1;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

    typedef enum logic [0:0] {
        CMD_POLAR  = 1'b0,
        CMD_ARCADE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                      command;
        logic [15:0]               heading;
        logic signed [POW_W-1:0]   polar_p;
        logic [31:0]               polar_phi;
        logic signed [POW_W-1:0]   turn;
    } side_t;

    typedef struct packed {
        logic signed [POW_W-1:0]   power;
        logic [31:0]               phi;
        logic signed [POW_W-1:0]   turn;
    } drive_t;

    typedef struct packed {
        logic signed [POW_W-1:0]   power;
        logic signed [ROT_W-1:0]   cosv;
        logic signed [ROT_W-1:0]   sinv;
        logic signed [POW_W-1:0]   turn;
    } trig_t;

    function automatic logic [31:0] atan_angle(input logic [IDX_W-1:0] idx);
        logic [31:0] a;
        case (idx)
            4'd0:    a = 32'h2000_0000;
            4'd1:    a = 32'h12E4_051E;
            4'd2:    a = 32'h09FB_385B;
            4'd3:    a = 32'h0511_11D4;
            4'd4:    a = 32'h028B_0D43;
            4'd5:    a = 32'h0145_D7E1;
            4'd6:    a = 32'h00A2_F61E;
            4'd7:    a = 32'h0051_7C55;
            4'd8:    a = 32'h0028_BE53;
            4'd9:    a = 32'h0014_5F2F;
            4'd10:   a = 32'h000A_2F98;
            4'd11:   a = 32'h0005_17CC;
            4'd12:   a = 32'h0002_8BE6;
            4'd13:   a = 32'h0001_45F3;
            4'd14:   a = 32'h0000_A2FA;
            4'd15:   a = 32'h0000_517D;
            default: a = 32'h0000_0000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/hxdm_vec.sv
// Front end: request decode, polar clamp, turn scaling and a pipelined vectoring CORDIC
// that yields the drive power and angle of arcade requests. Depends on hxdm_pkg.
`default_nettype none

module hxdm_vec
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              command,
    input  wire logic signed [15:0]                stick_x,
    input  wire logic signed [15:0]                stick_y,
    input  wire logic [15:0]                       heading,
    input  wire logic signed [15:0]                drive_power,
    input  wire logic [15:0]                       drive_angle,
    input  wire logic signed [15:0]                turn_amount,
    input  wire logic [hxdm_pkg::SPEED_W-1:0]      min_speed,
    input  wire logic [hxdm_pkg::SPEED_W-1:0]      max_speed,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output hxdm_pkg::drive_t                       out_data
);

    localparam int N = hxdm_pkg::ITERS + 3;
    localparam int W = hxdm_pkg::VEC_W;

    logic [N-1:0]               vld_reg;
    logic [N:0]                 rdy;
    logic signed [W-1:0]        x_reg [0:hxdm_pkg::ITERS];
    logic signed [W-1:0]        y_reg [0:hxdm_pkg::ITERS];
    logic [31:0]                z_reg [0:hxdm_pkg::ITERS];
    hxdm_pkg::side_t            side_reg [0:hxdm_pkg::ITERS+1];
    logic [hxdm_pkg::MAG_W-1:0] mag_reg;
    hxdm_pkg::drive_t           out_reg;

    logic signed [W-1:0]        xs, ys;
    logic signed [16:0]         mag_raw;
    logic signed [16:0]         mag_min;
    logic signed [16:0]         mag_lim;
    logic signed [15:0]         turn_sat;
    logic signed [23:0]         turn_scaled;
    hxdm_pkg::side_t            side_next;
    logic signed [63:0]         mag_prod;
    logic signed [63:0]         mag_shift;
    logic [hxdm_pkg::MAG_W-1:0] mag_next;
    logic [44:0]                pow_prod;
    hxdm_pkg::drive_t           out_next;

    assign rdy[N] = out_ready;
    for (genvar g = 0; g < N; g++) begin : g_rdy
        assign rdy[g] = !vld_reg[g] || rdy[g+1];
    end
    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        xs = W'(stick_x) <<< 14;
        ys = W'(stick_y) <<< 14;
        mag_raw = (drive_power < 0) ? -17'(drive_power) : 17'(drive_power);
        mag_min = (mag_raw < $signed({2'b00, min_speed})) ? $signed({2'b00, min_speed})
                                                          : mag_raw;
        mag_lim = (mag_min > $signed({2'b00, max_speed})) ? $signed({2'b00, max_speed})
                                                          : mag_min;
        if (turn_amount > 16'sd16384)
        begin
            turn_sat = 16'sd16384;
        end
        else if (turn_amount < -16'sd16384)
        begin
            turn_sat = -16'sd16384;
        end
        else
        begin
            turn_sat = turn_amount;
        end
        turn_scaled = (24'(turn_sat) * 24'sd127 + 24'sd32) >>> 6;
        side_next.command = command;
        side_next.heading = heading;
        side_next.polar_p = (drive_power < 0) ? -mag_lim : mag_lim;
        side_next.polar_phi = {drive_angle, 16'h0000};
        side_next.turn = (command == hxdm_pkg::CMD_ARCADE) ? 17'(turn_scaled)
                                                           : 17'(turn_amount);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            if (stick_x < 0)
            begin
                x_reg[0] <= -xs;
                y_reg[0] <= -ys;
                z_reg[0] <= hxdm_pkg::HALF_TURN;
            end
            else
            begin
                x_reg[0] <= xs;
                y_reg[0] <= ys;
                z_reg[0] <= '0;
            end
            side_reg[0] <= side_next;
        end
    end

    for (genvar g = 0; g < hxdm_pkg::ITERS; g++) begin : g_iter
        logic signed [W-1:0] dx, dy;
        logic [31:0]         at;
        assign dx = y_reg[g] >>> g;
        assign dy = x_reg[g] >>> g;
        assign at = hxdm_pkg::atan_angle(hxdm_pkg::IDX_W'(g));
        always_ff @(posedge clk)
        begin
            if (rdy[g+1])
            begin
                if (y_reg[g] >= 0)
                begin
                    x_reg[g+1] <= x_reg[g] + dx;
                    y_reg[g+1] <= y_reg[g] - dy;
                    z_reg[g+1] <= z_reg[g] + at;
                end
                else
                begin
                    x_reg[g+1] <= x_reg[g] - dx;
                    y_reg[g+1] <= y_reg[g] + dy;
                    z_reg[g+1] <= z_reg[g] - at;
                end
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    always_comb
    begin
        mag_prod = 64'(x_reg[hxdm_pkg::ITERS]) * $signed({33'd0, hxdm_pkg::GAIN_INV});
        mag_shift = mag_prod >>> 30;
        if (mag_shift > 64'sd268435456)
        begin
            mag_next = hxdm_pkg::MAG_W'(29'h1000_0000);
        end
        else if (mag_shift < 0)
        begin
            mag_next = '0;
        end
        else
        begin
            mag_next = mag_shift[hxdm_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[hxdm_pkg::ITERS+1])
        begin
            mag_reg <= mag_next;
            side_reg[hxdm_pkg::ITERS+1] <= side_reg[hxdm_pkg::ITERS];
        end
    end

    always_comb
    begin
        pow_prod = 45'(mag_reg) * 45'(hxdm_pkg::ARC_FULL) + 45'h800_0000;
        out_next.turn = side_reg[hxdm_pkg::ITERS+1].turn;
        if (side_reg[hxdm_pkg::ITERS+1].command == hxdm_pkg::CMD_ARCADE)
        begin
            out_next.power = $signed(hxdm_pkg::POW_W'(pow_prod[44:28]));
            out_next.phi = z_reg[hxdm_pkg::ITERS]
                           - {side_reg[hxdm_pkg::ITERS+1].heading, 16'h0000}
                           + hxdm_pkg::EIGHTH_TURN;
        end
        else
        begin
            out_next.power = side_reg[hxdm_pkg::ITERS+1].polar_p;
            out_next.phi = side_reg[hxdm_pkg::ITERS+1].polar_phi + hxdm_pkg::EIGHTH_TURN;
        end
    end

    logic [31:0] z_hold_reg;
    always_ff @(posedge clk)
    begin
        if (rdy[hxdm_pkg::ITERS+1])
        begin
            z_hold_reg <= z_reg[hxdm_pkg::ITERS];
        end
    end

    hxdm_pkg::drive_t out_fix;
    always_comb
    begin
        out_fix = out_next;
        if (side_reg[hxdm_pkg::ITERS+1].command == hxdm_pkg::CMD_ARCADE)
        begin
            out_fix.phi = z_hold_reg - {side_reg[hxdm_pkg::ITERS+1].heading, 16'h0000}
                          + hxdm_pkg::EIGHTH_TURN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[N-1])
        begin
            out_reg <= out_fix;
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_data = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/hxdm_rot.sv
// Pipelined rotation CORDIC: cosine and sine of each request's wheel angle.
// Depends on hxdm_pkg.
`default_nettype none

module hxdm_rot
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hxdm_pkg::drive_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output hxdm_pkg::trig_t     out_data
);

    localparam int N = hxdm_pkg::ITERS + 2;
    localparam int W = hxdm_pkg::ROT_W;

    logic [N-1:0]               vld_reg;
    logic [N:0]                 rdy;
    logic signed [W-1:0]        x_reg [0:hxdm_pkg::ITERS];
    logic signed [W-1:0]        y_reg [0:hxdm_pkg::ITERS];
    logic signed [W-1:0]        z_reg [0:hxdm_pkg::ITERS];
    logic                       flip_reg [0:hxdm_pkg::ITERS];
    logic signed [hxdm_pkg::POW_W-1:0] p_reg [0:hxdm_pkg::ITERS];
    logic signed [hxdm_pkg::POW_W-1:0] t_reg [0:hxdm_pkg::ITERS];
    hxdm_pkg::trig_t            out_reg;

    logic                       flip;
    logic [31:0]                phi_f;

    assign rdy[N] = out_ready;
    for (genvar g = 0; g < N; g++) begin : g_rdy
        assign rdy[g] = !vld_reg[g] || rdy[g+1];
    end
    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
                end
            end
        end
    end

    assign flip = in_data.phi[31] ^ in_data.phi[30];
    assign phi_f = flip ? in_data.phi + hxdm_pkg::HALF_TURN : in_data.phi;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            x_reg[0] <= W'(hxdm_pkg::GAIN_INV);
            y_reg[0] <= '0;
            z_reg[0] <= W'($signed(phi_f));
            flip_reg[0] <= flip;
            p_reg[0] <= in_data.power;
            t_reg[0] <= in_data.turn;
        end
    end

    for (genvar g = 0; g < hxdm_pkg::ITERS; g++) begin : g_iter
        logic signed [W-1:0] dx, dy, at;
        assign dx = y_reg[g] >>> g;
        assign dy = x_reg[g] >>> g;
        assign at = W'(hxdm_pkg::atan_angle(hxdm_pkg::IDX_W'(g)));
        always_ff @(posedge clk)
        begin
            if (rdy[g+1])
            begin
                if (z_reg[g] >= 0)
                begin
                    x_reg[g+1] <= x_reg[g] - dx;
                    y_reg[g+1] <= y_reg[g] + dy;
                    z_reg[g+1] <= z_reg[g] - at;
                end
                else
                begin
                    x_reg[g+1] <= x_reg[g] + dx;
                    y_reg[g+1] <= y_reg[g] - dy;
                    z_reg[g+1] <= z_reg[g] + at;
                end
                flip_reg[g+1] <= flip_reg[g];
                p_reg[g+1] <= p_reg[g];
                t_reg[g+1] <= t_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[N-1])
        begin
            out_reg.power <= p_reg[hxdm_pkg::ITERS];
            out_reg.turn <= t_reg[hxdm_pkg::ITERS];
            out_reg.cosv <= flip_reg[hxdm_pkg::ITERS] ? -x_reg[hxdm_pkg::ITERS]
                                                      : x_reg[hxdm_pkg::ITERS];
            out_reg.sinv <= flip_reg[hxdm_pkg::ITERS] ? -y_reg[hxdm_pkg::ITERS]
                                                      : y_reg[hxdm_pkg::ITERS];
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_data = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/hxdm_out.sv
// Back end: power times cosine and sine with rounding, then turn mixing and
// saturation of the four wheel commands. Depends on hxdm_pkg.
`default_nettype none

module hxdm_out
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire hxdm_pkg::trig_t                    in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [4*hxdm_pkg::WHEEL_W-1:0]          out_data
);

    localparam int N = 2;
    localparam int PW = hxdm_pkg::POW_W + hxdm_pkg::ROT_W;

    logic [N-1:0]                       vld_reg;
    logic [N:0]                         rdy;
    logic signed [PW-1:0]               pc_reg, ps_reg;
    logic signed [hxdm_pkg::POW_W-1:0]  t_reg;
    logic [4*hxdm_pkg::WHEEL_W-1:0]     out_reg;

    logic signed [PW-1:0]               pc_next, ps_next;
    logic signed [PW-1:0]               fl, fr, bl, br;

    assign rdy[N] = out_ready;
    for (genvar g = 0; g < N; g++) begin : g_rdy
        assign rdy[g] = !vld_reg[g] || rdy[g+1];
    end
    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
                end
            end
        end
    end

    assign pc_next = (PW'(in_data.power) * PW'(in_data.cosv) + (PW'(1) <<< 29)) >>> 30;
    assign ps_next = (PW'(in_data.power) * PW'(in_data.sinv) + (PW'(1) <<< 29)) >>> 30;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pc_reg <= pc_next;
            ps_reg <= ps_next;
            t_reg <= in_data.turn;
        end
    end

    function automatic logic [hxdm_pkg::WHEEL_W-1:0] wheel_sat(input logic signed [PW-1:0] v);
        logic [hxdm_pkg::WHEEL_W-1:0] r;
        if (v > PW'(65535))
        begin
            r = 17'h0FFFF;
        end
        else if (v < -PW'(65536))
        begin
            r = 17'h10000;
        end
        else
        begin
            r = v[hxdm_pkg::WHEEL_W-1:0];
        end
        return r;
    endfunction

    assign fl = ps_reg + PW'(t_reg);
    assign fr = pc_reg - PW'(t_reg);
    assign bl = pc_reg + PW'(t_reg);
    assign br = ps_reg - PW'(t_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            out_reg <= {wheel_sat(br), wheel_sat(bl), wheel_sat(fr), wheel_sat(fl)};
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_data = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/holonomic_x_drive_wheel_mixer.sv
// Pipeline: a front end, a rotation unit and a back end, with one CORDIC iteration per
// stage in both CORDIC units.
// Throughput: one request per cycle while the output accepts; every stage advances when the stage after it is
// empty or advancing, so a stall at the output fills bubbles before input is held off.
// Reset: rst_n clears all valid bits and sets min_speed to 0 and max_speed to 32512.
// Top level of the X-drive wheel mixer; depends on hxdm_pkg, hxdm_vec, hxdm_rot, hxdm_out.
`default_nettype none

module holonomic_x_drive_wheel_mixer
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // stick_x, stick_y, heading, drive_power, drive_angle, turn_amount
    input  wire logic [95:0]                       s_axis_tdata,
    // command
    input  wire logic [0:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // front_left_drive, front_right_drive, back_left_drive, back_right_drive, zero pad
    output logic [71:0]                            m_axis_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hxdm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hxdm_pkg::SPEED_W-1:0]      cfg_data
);

    logic [hxdm_pkg::SPEED_W-1:0]     min_speed_reg;
    logic [hxdm_pkg::SPEED_W-1:0]     max_speed_reg;
    logic                             vec_valid, vec_ready;
    hxdm_pkg::drive_t                 vec_data;
    logic                             rot_valid, rot_ready;
    hxdm_pkg::trig_t                  rot_data;
    logic [4*hxdm_pkg::WHEEL_W-1:0]   wheels;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg <= hxdm_pkg::MIN_SPEED_RESET;
            max_speed_reg <= hxdm_pkg::MAX_SPEED_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hxdm_pkg::REG_MIN_SPEED: min_speed_reg <= cfg_data;
                hxdm_pkg::REG_MAX_SPEED: max_speed_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    hxdm_vec u_vec
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .command     (s_axis_tuser[0]),
        .stick_x     ($signed(s_axis_tdata[15:0])),
        .stick_y     ($signed(s_axis_tdata[31:16])),
        .heading     (s_axis_tdata[47:32]),
        .drive_power ($signed(s_axis_tdata[63:48])),
        .drive_angle (s_axis_tdata[79:64]),
        .turn_amount ($signed(s_axis_tdata[95:80])),
        .min_speed   (min_speed_reg),
        .max_speed   (max_speed_reg),
        .out_valid   (vec_valid),
        .out_ready   (vec_ready),
        .out_data    (vec_data)
    );

    hxdm_rot u_rot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec_valid),
        .in_ready  (vec_ready),
        .in_data   (vec_data),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    hxdm_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (wheels)
    );

    assign m_axis_tdata = {4'b0000, wheels};

endmodule

`default_nettype wire

>>> rtl/core/hxdm_checker.sv
// Port-level checks for the X-drive wheel mixer, bound to its top level.
// Depends on holonomic_x_drive_wheel_mixer's ports only.
`default_nettype none

module hxdm_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [71:0]  m_axis_tdata,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("Result shown during reset.");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Request refused while no result waits.");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("Configuration write refused.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result changed.");

endmodule

bind holonomic_x_drive_wheel_mixer hxdm_checker u_hxdm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire
